// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, character codes, operation codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int TAB_STOP      = 8;

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(SCREEN_WIDTH);
  localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
  localparam int TAB_W      = $clog2(TAB_STOP) + 1;
  localparam int CELL_W     = 16;

  localparam logic [7:0] CODE_TAB        = 8'd9;
  localparam logic [7:0] CODE_NEWLINE    = 8'd10;
  localparam logic [7:0] CODE_SPACE      = 8'd32;
  localparam logic [7:0] RESET_ATTRIBUTE = 8'd7;

  typedef enum logic [2:0] {
    OP_PUT_CHAR   = 3'd0,
    OP_SET_CURSOR = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_WRITE_CELL = 3'd3,
    OP_READ_CELL  = 3'd4
  } op_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic fill;
    logic fill_reset_attr;
    logic copy;
    logic cursor_last;
    logic cursor_row1;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scroll;
    logic clear;
    logic fill_last;
    logic copy_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data with read enable.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console controller
// Sequences request capture, execution, screen sweeps and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::dp_status_t status,
  output tcw_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_BLANK,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.fill            = 1'b1;
        cmd.fill_reset_attr = 1'b1;
        if (status.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.scroll) begin
          state_next = ST_COPY;
        end else if (status.clear) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        if (status.copy_done) begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd.fill = 1'b1;
        if (status.fill_last) begin
          cmd.cursor_last = 1'b1;
          state_next      = ST_RESULT;
        end
      end
      ST_CLEAR: begin
        cmd.fill = 1'b1;
        if (status.fill_last) begin
          cmd.cursor_row1 = 1'b1;
          state_next      = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// Text console datapath
// Screen store, cursor and column registers, sweep pointers, attribute
// register and the output register.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tcw_pkg::dp_cmd_t    cmd,
  output tcw_pkg::dp_status_t status,
  input  logic [2:0]          operation,
  input  logic [7:0]          char_code,
  input  logic [6:0]          column,
  input  logic [4:0]          row,
  input  logic                cfg_valid,
  input  logic [7:0]          text_attribute,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [10:0]         cursor_position,
  output logic [7:0]          cell_char,
  output logic [7:0]          cell_attr
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::COL_W;
  localparam int TW = tcw_pkg::TAB_W;

  tcw_pkg::op_t op_q;
  logic [7:0]   ch_q;
  logic [6:0]   col_q;
  logic [4:0]   row_q;
  logic [7:0]   attr;

  logic [AW-1:0] cursor;
  logic [CW-1:0] col;
  logic [AW-1:0] cursor_next;
  logic [CW-1:0] col_next;

  logic [AW-1:0] wptr;
  logic [AW-1:0] src;
  logic          src_end;
  logic          pend;
  logic          rd_hit;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [tcw_pkg::CELL_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [tcw_pkg::CELL_W-1:0] rdata;

  logic [TW-1:0]   tab_step;
  logic [AW:0]     off_n;
  logic [CW:0]     col_n;
  logic [CW-1:0]   set_col;
  logic [4:0]      set_row;
  logic [AW-1:0]   set_off;
  logic [AW-1:0]   req_addr;
  logic            in_range;
  logic [7:0]      fill_attr;

  always_comb begin
    tab_step = TW'(tcw_pkg::TAB_STOP) - TW'(cursor % tcw_pkg::TAB_STOP);
    off_n    = {1'b0, cursor} + (AW+1)'(1);
    col_n    = {1'b0, col} + (CW+1)'(1);
    if (ch_q == tcw_pkg::CODE_TAB) begin
      off_n = {1'b0, cursor} + (AW+1)'(tab_step);
      col_n = {1'b0, col} + (CW+1)'(tab_step);
    end else if (ch_q == tcw_pkg::CODE_NEWLINE) begin
      off_n = {1'b0, cursor} + (AW+1)'(tcw_pkg::SCREEN_WIDTH) - (AW+1)'(col);
      col_n = '0;
    end
    if (col_n >= (CW+1)'(tcw_pkg::SCREEN_WIDTH)) begin
      col_n = col_n - (CW+1)'(tcw_pkg::SCREEN_WIDTH);
    end

    set_col = (col_q >= 7'(tcw_pkg::SCREEN_WIDTH)) ?
              CW'(tcw_pkg::SCREEN_WIDTH - 1) : CW'(col_q);
    set_row = (row_q >= 5'(tcw_pkg::SCREEN_HEIGHT)) ?
              5'(tcw_pkg::SCREEN_HEIGHT - 1) : row_q;
    set_off = AW'(set_row) * AW'(tcw_pkg::SCREEN_WIDTH) + AW'(set_col);

    in_range = (col_q < 7'(tcw_pkg::SCREEN_WIDTH)) &&
               (row_q < 5'(tcw_pkg::SCREEN_HEIGHT));
    req_addr = AW'(row_q) * AW'(tcw_pkg::SCREEN_WIDTH) + AW'(col_q);

    status.scroll    = (op_q == tcw_pkg::OP_PUT_CHAR) &&
                       (off_n >= (AW+1)'(tcw_pkg::CELL_COUNT));
    status.clear     = (op_q == tcw_pkg::OP_CLEAR);
    status.fill_last = (wptr == AW'(tcw_pkg::CELL_COUNT - 1));
    status.copy_done = src_end && !pend;
    status.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    fill_attr = cmd.fill_reset_attr ? tcw_pkg::RESET_ATTRIBUTE : attr;
    we        = 1'b0;
    waddr     = wptr;
    wdata     = {fill_attr, tcw_pkg::CODE_SPACE};
    re        = 1'b0;
    raddr     = req_addr;
    if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.copy) begin
      we    = pend;
      wdata = rdata;
      re    = !src_end;
      raddr = src;
    end else if (cmd.exec) begin
      case (op_q)
        tcw_pkg::OP_PUT_CHAR: begin
          we    = (ch_q != tcw_pkg::CODE_TAB) && (ch_q != tcw_pkg::CODE_NEWLINE);
          waddr = cursor;
          wdata = {attr, ch_q};
        end
        tcw_pkg::OP_WRITE_CELL: begin
          we    = in_range;
          waddr = req_addr;
          wdata = {attr, ch_q};
        end
        tcw_pkg::OP_READ_CELL: begin
          re = in_range;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cursor_next = cursor;
    col_next    = col;
    if (cmd.exec) begin
      case (op_q)
        tcw_pkg::OP_PUT_CHAR: begin
          if (!status.scroll) begin
            cursor_next = off_n[AW-1:0];
            col_next    = col_n[CW-1:0];
          end
        end
        tcw_pkg::OP_SET_CURSOR: begin
          cursor_next = set_off;
          col_next    = set_col;
        end
        default: begin
          cursor_next = cursor;
        end
      endcase
    end
    if (cmd.cursor_last) begin
      cursor_next = AW'((tcw_pkg::SCREEN_HEIGHT - 1) * tcw_pkg::SCREEN_WIDTH);
      col_next    = '0;
    end
    if (cmd.cursor_row1) begin
      cursor_next = AW'(tcw_pkg::SCREEN_WIDTH);
      col_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q  <= tcw_pkg::op_t'(operation);
      ch_q  <= char_code;
      col_q <= column;
      row_q <= row;
    end
    if (cmd.exec) begin
      rd_hit <= (op_q == tcw_pkg::OP_READ_CELL) && in_range;
    end
    if (cmd.load_out) begin
      cursor_position <= 11'(cursor);
      cell_char       <= rd_hit ? rdata[7:0] : 8'd0;
      cell_attr       <= rd_hit ? rdata[15:8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr      <= tcw_pkg::RESET_ATTRIBUTE;
      cursor    <= '0;
      col       <= '0;
      wptr      <= '0;
      src       <= '0;
      src_end   <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        attr <= text_attribute;
      end
      cursor <= cursor_next;
      col    <= col_next;
      if (cmd.exec && status.scroll) begin
        src     <= AW'(2 * tcw_pkg::SCREEN_WIDTH);
        wptr    <= AW'(tcw_pkg::SCREEN_WIDTH);
        src_end <= 1'b0;
        pend    <= 1'b0;
      end else if (cmd.exec && status.clear) begin
        wptr <= '0;
      end else if (cmd.fill) begin
        wptr <= wptr + AW'(1);
      end else if (cmd.copy) begin
        if (!src_end) begin
          src <= src + AW'(1);
          if (src == AW'(tcw_pkg::CELL_COUNT - 1)) begin
            src_end <= 1'b1;
          end
        end
        pend <= !src_end;
        if (pend) begin
          wptr <= wptr + AW'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(tcw_pkg::CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

// ===== src/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Teletype console over an 80 x 25 character-cell screen store.
//
// Requests enter on in_valid/in_ready with operation, char_code, column and
// row; every request returns one result on out_valid/out_ready carrying
// cursor_position, cell_char and cell_attr. The attribute register is written
// on cfg_valid/cfg_ready with text_attribute; cfg_ready is always high.
// Requests are handled one at a time. An ordinary request (put_char without
// scroll, set_cursor, write_cell, read_cell) passes through the accept,
// execute and result steps of the controller around the screen RAM. A
// put_char that scrolls moves 1840 cells through the RAM read and write
// ports and blanks the last row. clear_screen walks all 2000 cells.
// After reset the block clears all 2000 cells of the store with in_ready
// low; configuration writes are taken during that pass.
// When the receiver stalls, the finished result holds in the output
// register; the next request is accepted and runs, then waits for it.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [7:0]  char_code,
  input  logic [6:0]  column,
  input  logic [4:0]  row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] cursor_position,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  text_attribute
);

  tcw_pkg::dp_cmd_t    cmd;
  tcw_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  tcw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .char_code      (char_code),
    .column         (column),
    .row            (row),
    .cfg_valid      (cfg_valid),
    .text_attribute (text_attribute),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_position(cursor_position),
    .cell_char      (cell_char),
    .cell_attr      (cell_attr)
  );

  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_position < 11'(tcw_pkg::CELL_COUNT)))
    else $error("cursor beyond screen end");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in work");

  a_sweep_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.fill && cmd.copy) && !(cmd.exec && cmd.load_out))
    else $error("conflicting datapath commands");

endmodule

// ===== test/text_console_checker.sv =====
// ----------------------------------------------------------------------------
// Text console writer checker
// Watches the request, result and attribute channels of the console. Keeps a
// model of the screen store, the cursor and the attribute register, predicts
// one result per accepted request and compares every returned result field
// by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module text_console_checker
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [7:0]  char_code,
  input  logic [6:0]  column,
  input  logic [4:0]  row,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] cursor_position,
  input  logic [7:0]  cell_char,
  input  logic [7:0]  cell_attr,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  text_attribute,
  input  logic        end_of_test,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [10:0] cursor;
    logic [7:0]  ch;
    logic [7:0]  attr;
  } console_result_t;

  logic [15:0]     screen [CELL_COUNT];
  int unsigned     cursor_ofs;
  logic [7:0]      attribute;
  console_result_t expected_results [$];
  int              mismatches = 0;
  int              leftovers = 0;

  assign fail_count = mismatches + leftovers;

  function automatic console_result_t apply_request(input logic [2:0] op,
                                                    input logic [7:0] ch,
                                                    input logic [6:0] col,
                                                    input logic [4:0] rw);
    int unsigned     c;
    int unsigned     r;
    int unsigned     ofs;
    console_result_t res;
    c   = col;
    r   = rw;
    res = '0;
    case (op)
      OP_PUT_CHAR: begin
        ofs = cursor_ofs;
        if (ch == CODE_TAB) begin
          ofs += TAB_STOP - ofs % TAB_STOP;
        end else if (ch == CODE_NEWLINE) begin
          ofs += SCREEN_WIDTH - ofs % SCREEN_WIDTH;
        end else begin
          if (ofs < CELL_COUNT) screen[ofs] = {attribute, ch};
          ofs++;
        end
        cursor_ofs = ofs;
        if (ofs >= CELL_COUNT) begin
          // keep row 0, move rows 2..H-1 up, blank the last row
          for (int i = SCREEN_WIDTH; i < (SCREEN_HEIGHT - 1) * SCREEN_WIDTH; i++)
            screen[i] = screen[i + SCREEN_WIDTH];
          for (int i = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH; i < CELL_COUNT; i++)
            screen[i] = {attribute, CODE_SPACE};
          cursor_ofs = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;
        end
      end
      OP_SET_CURSOR: begin
        if (c >= SCREEN_WIDTH) c = SCREEN_WIDTH - 1;
        if (r >= SCREEN_HEIGHT) r = SCREEN_HEIGHT - 1;
        cursor_ofs = r * SCREEN_WIDTH + c;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen[i] = {attribute, CODE_SPACE};
        cursor_ofs = SCREEN_WIDTH;
      end
      OP_WRITE_CELL: begin
        if (c < SCREEN_WIDTH && r < SCREEN_HEIGHT) screen[r * SCREEN_WIDTH + c] = {attribute, ch};
      end
      OP_READ_CELL: begin
        if (c < SCREEN_WIDTH && r < SCREEN_HEIGHT) begin
          res.ch   = screen[r * SCREEN_WIDTH + c][7:0];
          res.attr = screen[r * SCREEN_WIDTH + c][15:8];
        end
      end
      default: begin
      end
    endcase
    res.cursor = cursor_ofs[10:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      foreach (screen[i]) screen[i] = {RESET_ATTRIBUTE, CODE_SPACE};
      cursor_ofs = 0;
      attribute  = RESET_ATTRIBUTE;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) attribute = text_attribute;
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(operation, char_code, column, row));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t ns: result with no request waiting, cursor %0d char %0d attr %0d",
                     $time, cursor_position, cell_char, cell_attr);
        end else begin
          want = expected_results.pop_front();
          check_field("cursor_position", want.cursor, cursor_position);
          check_field("cell_char", 11'(want.ch), 11'(cell_char));
          check_field("cell_attr", 11'(want.attr), 11'(cell_attr));
        end
      end
    end
  end

  always @(posedge end_of_test) begin
    leftovers = expected_results.size();
    if (leftovers != 0) $display("%0d results never returned", leftovers);
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives directed and random console requests with random gaps on both
// channels, rewrites the attribute register between phases while the block
// is idle, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_REQUESTS = 305;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [7:0]  char_code = '0;
  logic [6:0]  column = '0;
  logic [4:0]  row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] cursor_position;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  text_attribute = '0;
  logic        end_of_test = 1'b0;
  int          fail_count;

  int          requests_sent = 0;
  int          results_seen = 0;
  int          in_gap_pct = 0;
  int          out_stall_pct = 0;
  int          stall_left = 0;
  logic [6:0]  recent_col = '0;
  logic [4:0]  recent_row = '0;

  text_console_writer u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .char_code       (char_code),
    .column          (column),
    .row             (row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position),
    .cell_char       (cell_char),
    .cell_attr       (cell_attr),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .text_attribute  (text_attribute)
  );

  text_console_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .char_code       (char_code),
    .column          (column),
    .row             (row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position),
    .cell_char       (cell_char),
    .cell_attr       (cell_attr),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .text_attribute  (text_attribute),
    .end_of_test     (end_of_test),
    .fail_count      (fail_count)
  );

  always #4ns clk = ~clk;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) results_seen <= results_seen + 1;
  end

  task automatic send_request(input logic [2:0] op, input logic [7:0] ch,
                              input logic [6:0] col, input logic [4:0] rw);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    char_code <= ch;
    column    <= col;
    row       <= rw;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    cfg_valid      <= 1'b1;
    text_attribute <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #150ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned run_len;
    int          phase_start;
    logic [7:0]  ch;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    in_gap_pct    = 20;
    out_stall_pct = 20;
    send_request(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_request(OP_READ_CELL, 8'hFF, 7'd79, 5'd24);
    send_request(OP_READ_CELL, 8'h00, 7'd80, 5'd0);
    send_request(OP_READ_CELL, 8'h00, 7'd0, 5'd25);
    send_request(OP_READ_CELL, 8'h00, 7'd127, 5'd31);
    send_request(OP_PUT_CHAR, 8'h41, 7'd127, 5'd31);
    send_request(OP_PUT_CHAR, 8'h00, 7'd0, 5'd0);
    send_request(OP_PUT_CHAR, 8'hFF, 7'd0, 5'd0);
    send_request(OP_PUT_CHAR, CODE_TAB, 7'd0, 5'd0);
    send_request(OP_PUT_CHAR, CODE_NEWLINE, 7'd0, 5'd0);
    send_request(OP_READ_CELL, 8'h00, 7'd1, 5'd0);
    send_request(OP_SET_CURSOR, 8'h00, 7'd127, 5'd31);
    send_request(OP_PUT_CHAR, 8'h5A, 7'd0, 5'd0);
    send_request(OP_SET_CURSOR, 8'h00, 7'd79, 5'd24);
    send_request(OP_PUT_CHAR, CODE_TAB, 7'd0, 5'd0);
    send_request(OP_PUT_CHAR, CODE_NEWLINE, 7'd0, 5'd0);
    send_request(OP_WRITE_CELL, 8'h53, 7'd5, 5'd0);
    send_request(OP_WRITE_CELL, 8'h78, 7'd80, 5'd3);
    send_request(OP_WRITE_CELL, 8'h78, 7'd3, 5'd25);
    send_request(OP_READ_CELL, 8'h00, 7'd5, 5'd0);
    send_request(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_request(OP_UNUSED_FIRST, 8'hFF, 7'd127, 5'd31);
    send_request(OP_UNUSED_LAST, 8'h00, 7'd0, 5'd0);
    wait_idle();
    write_attribute(8'hFF);
    send_request(OP_PUT_CHAR, 8'h51, 7'd0, 5'd0);
    send_request(OP_READ_CELL, 8'h00, 7'd0, 5'd24);
    send_request(OP_READ_CELL, 8'h00, 7'd5, 5'd0);
    send_request(OP_CLEAR, 8'h00, 7'd0, 5'd0);
    send_request(OP_READ_CELL, 8'h00, 7'd5, 5'd0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      if (phase == 0) write_attribute(8'h00);
      else if (phase == RANDOM_PHASES - 1) write_attribute(8'hFF);
      else write_attribute(8'($urandom_range(0, 255)));
      if (phase % 3 == 1 || phase == RANDOM_PHASES - 1) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = $urandom_range(10, 60);
        out_stall_pct = $urandom_range(10, 60);
      end
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_REQUESTS) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          run_len = $urandom_range(1, 12);
          repeat (run_len) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) ch = CODE_TAB;
            else if (pick == 1) ch = CODE_NEWLINE;
            else ch = 8'($urandom_range(0, 255));
            send_request(OP_PUT_CHAR, ch, 7'($urandom_range(0, 127)),
                         5'($urandom_range(0, 31)));
          end
        end else if (pick < 55) begin
          recent_col = 7'($urandom_range(0, 127));
          recent_row = 5'($urandom_range(0, 31));
          send_request(OP_SET_CURSOR, 8'($urandom_range(0, 255)), recent_col, recent_row);
        end else if (pick < 57) begin
          send_request(OP_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                       5'($urandom_range(0, 31)));
        end else if (pick < 72) begin
          if ($urandom_range(0, 4) == 0) begin
            recent_col = 7'($urandom_range(0, 127));
            recent_row = 5'($urandom_range(0, 31));
          end else begin
            recent_col = 7'($urandom_range(0, SCREEN_WIDTH - 1));
            recent_row = 5'($urandom_range(0, SCREEN_HEIGHT - 1));
          end
          send_request(OP_WRITE_CELL, 8'($urandom_range(0, 255)), recent_col, recent_row);
        end else if (pick < 93) begin
          case ($urandom_range(0, 3))
            0, 1: send_request(OP_READ_CELL, 8'($urandom_range(0, 255)), recent_col,
                               recent_row);
            2: send_request(OP_READ_CELL, 8'($urandom_range(0, 255)),
                            7'($urandom_range(0, 127)), recent_row);
            default: send_request(OP_READ_CELL, 8'($urandom_range(0, 255)),
                                  7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
          endcase
        end else begin
          send_request(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                       8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                       5'($urandom_range(0, 31)));
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
